>>> sv/pcss_pkg.sv
package pcss_pkg;

  // Field widths
  localparam int ADDR_W  = 24;
  localparam int HW_W    = 16;
  localparam int OP_W    = 8;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 3;
  localparam int TGT_W   = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TRAINERR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BADOP    = 3'd4;

  // Write targets
  localparam logic [TGT_W-1:0] TGT_PHY0 = 2'd0;
  localparam logic [TGT_W-1:0] TGT_BOTH = 2'd2;

  // Entry ops
  localparam logic [OP_W-1:0] OP_WR_BOTH = 8'd2;
  localparam logic [OP_W-1:0] OP_RANGE   = 8'd3;
  localparam logic [OP_W-1:0] OP_WAIT0   = 8'd4;
  localparam logic [OP_W-1:0] OP_WAIT1   = 8'd5;

  // Training message ids
  localparam logic [HW_W-1:0] MSG_SUCCESS = 16'h0007;
  localparam logic [HW_W-1:0] MSG_FAILURE = 16'h00ff;

  // Input function codes
  localparam logic FUNC_STREAM = 1'b0;
  localparam logic FUNC_MSG    = 1'b1;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic            func;
    logic [HW_W-1:0] halfword;
    logic            msg_phy;
    logic [HW_W-1:0] msg_id;
  } pcss_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TGT_W-1:0]  target;
    logic [ADDR_W-1:0] reg_address;
    logic [HW_W-1:0]   reg_data;
    logic [OP_W-1:0]   bad_op;
    logic              last;
  } pcss_out_t;

  // One queued command: an optional write beat followed by an optional tail beat
  typedef struct packed {
    logic              has_write;
    logic              tail_valid;
    logic [KIND_W-1:0] tail_kind;
    logic [TGT_W-1:0]  target;
    logic [ADDR_W-1:0] reg_address;
    logic [HW_W-1:0]   reg_data;
    logic [OP_W-1:0]   bad_op;
  } pcss_cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } pcss_qstat_t;

endpackage

>>> sv/pcss_front.sv
module pcss_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pcss_pkg::pcss_in_t             in_data,
  input  logic                           cfg_wr_en,
  input  logic [pcss_pkg::ADDR_W-1:0]    cfg_wr_data,
  input  pcss_pkg::pcss_qstat_t          qstat,
  output logic                           push,
  output pcss_pkg::pcss_cmd_t            push_cmd
);

  localparam logic [2:0] PH_HDR_LO = 3'd0;
  localparam logic [2:0] PH_HDR_HI = 3'd1;
  localparam logic [2:0] PH_SINGLE = 3'd2;
  localparam logic [2:0] PH_CNT_LO = 3'd3;
  localparam logic [2:0] PH_CNT_HI = 3'd4;
  localparam logic [2:0] PH_RANGE  = 3'd5;
  localparam logic [2:0] PH_WAIT   = 3'd6;
  localparam logic [2:0] PH_STOP   = 3'd7;

  logic [2:0]                    phase_r, phase_nxt;
  logic [pcss_pkg::HW_W-1:0]     header_low_r, header_low_nxt;
  logic [pcss_pkg::OP_W-1:0]     entry_op_r, entry_op_nxt;
  logic [pcss_pkg::ADDR_W-1:0]   write_address_r, write_address_nxt;
  logic [pcss_pkg::CNT_W-1:0]    range_remaining_r, range_remaining_nxt;
  logic [pcss_pkg::ADDR_W-1:0]   entries_done_r, entries_done_nxt;
  logic                          waited_phy_r, waited_phy_nxt;
  logic [pcss_pkg::ADDR_W-1:0]   entry_count_r;

  logic                          accept;
  logic [pcss_pkg::ADDR_W-1:0]   done_inc;
  logic                          inc_reached;
  logic [pcss_pkg::OP_W-1:0]     hdr_op;
  logic [pcss_pkg::CNT_W-1:0]    cnt_full;
  pcss_pkg::pcss_cmd_t           cmd;

  assign in_ready    = !qstat.full;
  assign accept      = in_valid && in_ready;
  assign done_inc    = entries_done_r + pcss_pkg::ADDR_W'(1);
  assign inc_reached = (done_inc >= entry_count_r);
  assign hdr_op      = in_data.halfword[15:8];
  assign cnt_full    = {in_data.halfword, range_remaining_r[pcss_pkg::HW_W-1:0]};

  // Decode one beat against the current phase
  always_comb begin
    phase_nxt           = phase_r;
    header_low_nxt      = header_low_r;
    entry_op_nxt        = entry_op_r;
    write_address_nxt   = write_address_r;
    range_remaining_nxt = range_remaining_r;
    entries_done_nxt    = entries_done_r;
    waited_phy_nxt      = waited_phy_r;
    cmd                 = '0;

    if (in_data.func == pcss_pkg::FUNC_MSG) begin
      if (phase_r == PH_WAIT && in_data.msg_phy == waited_phy_r) begin
        if (in_data.msg_id == pcss_pkg::MSG_SUCCESS) begin
          entries_done_nxt = done_inc;
          if (inc_reached) begin
            phase_nxt      = PH_STOP;
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = pcss_pkg::KIND_DONE;
          end else begin
            phase_nxt = PH_HDR_LO;
          end
        end else if (in_data.msg_id == pcss_pkg::MSG_FAILURE) begin
          phase_nxt      = PH_STOP;
          cmd.tail_valid = 1'b1;
          cmd.tail_kind  = pcss_pkg::KIND_TRAINERR;
          cmd.target     = {1'b0, waited_phy_r};
        end
      end
    end else begin
      unique case (phase_r)
        PH_HDR_LO: begin
          if (entries_done_r >= entry_count_r) begin
            phase_nxt      = PH_STOP;
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = pcss_pkg::KIND_DONE;
          end else begin
            header_low_nxt = in_data.halfword;
            phase_nxt      = PH_HDR_HI;
          end
        end
        PH_HDR_HI: begin
          entry_op_nxt      = hdr_op;
          write_address_nxt = {in_data.halfword[7:0], header_low_r};
          if (hdr_op <= pcss_pkg::OP_WR_BOTH) begin
            phase_nxt = PH_SINGLE;
          end else if (hdr_op == pcss_pkg::OP_RANGE) begin
            phase_nxt = PH_CNT_LO;
          end else if (hdr_op == pcss_pkg::OP_WAIT0 || hdr_op == pcss_pkg::OP_WAIT1) begin
            waited_phy_nxt = hdr_op[0];
            phase_nxt      = PH_WAIT;
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = pcss_pkg::KIND_WAIT;
            cmd.target     = {1'b0, hdr_op[0]};
          end else begin
            phase_nxt      = PH_STOP;
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = pcss_pkg::KIND_BADOP;
            cmd.bad_op     = hdr_op;
          end
        end
        PH_SINGLE: begin
          cmd.has_write    = 1'b1;
          cmd.target       = entry_op_r[pcss_pkg::TGT_W-1:0];
          cmd.reg_address  = write_address_r;
          cmd.reg_data     = in_data.halfword;
          entries_done_nxt = done_inc;
          if (inc_reached) begin
            phase_nxt      = PH_STOP;
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = pcss_pkg::KIND_DONE;
          end else begin
            phase_nxt = PH_HDR_LO;
          end
        end
        PH_CNT_LO: begin
          range_remaining_nxt = {{(pcss_pkg::CNT_W-pcss_pkg::HW_W){1'b0}}, in_data.halfword};
          phase_nxt           = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          range_remaining_nxt = cnt_full;
          if (cnt_full == '0) begin
            entries_done_nxt = done_inc;
            if (inc_reached) begin
              phase_nxt      = PH_STOP;
              cmd.tail_valid = 1'b1;
              cmd.tail_kind  = pcss_pkg::KIND_DONE;
            end else begin
              phase_nxt = PH_HDR_LO;
            end
          end else begin
            phase_nxt = PH_RANGE;
          end
        end
        PH_RANGE: begin
          cmd.has_write       = 1'b1;
          cmd.target          = pcss_pkg::TGT_BOTH;
          cmd.reg_address     = write_address_r;
          cmd.reg_data        = in_data.halfword;
          write_address_nxt   = write_address_r + pcss_pkg::ADDR_W'(1);
          range_remaining_nxt = range_remaining_r - pcss_pkg::CNT_W'(1);
          if (range_remaining_r == pcss_pkg::CNT_W'(1)) begin
            entries_done_nxt = done_inc;
            if (inc_reached) begin
              phase_nxt      = PH_STOP;
              cmd.tail_valid = 1'b1;
              cmd.tail_kind  = pcss_pkg::KIND_DONE;
            end else begin
              phase_nxt = PH_HDR_LO;
            end
          end
        end
        PH_WAIT, PH_STOP: begin
          // stream beats are dropped here
        end
        default: begin
        end
      endcase
    end
  end

  assign push     = accept && (cmd.has_write || cmd.tail_valid);
  assign push_cmd = cmd;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HDR_LO;
      header_low_r      <= '0;
      entry_op_r        <= '0;
      write_address_r   <= '0;
      range_remaining_r <= '0;
      entries_done_r    <= '0;
      waited_phy_r      <= 1'b0;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      header_low_r      <= header_low_nxt;
      entry_op_r        <= entry_op_nxt;
      write_address_r   <= write_address_nxt;
      range_remaining_r <= range_remaining_nxt;
      entries_done_r    <= entries_done_nxt;
      waited_phy_r      <= waited_phy_nxt;
    end
  end

  // Entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  // once stopped, nothing more is queued
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) |-> !push)
    else $error("front queued a command after stopping");

  // a range phase always has writes outstanding
  a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RANGE) |-> (range_remaining_r != '0))
    else $error("range phase with zero remaining count");
`endif

endmodule

>>> sv/pcss_queue.sv
module pcss_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pcss_pkg::pcss_cmd_t    push_cmd,
  input  logic                   pop,
  output pcss_pkg::pcss_cmd_t    head_cmd,
  output pcss_pkg::pcss_qstat_t  qstat
);

  pcss_pkg::pcss_cmd_t             mem [pcss_pkg::QDEPTH];
  logic [pcss_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [pcss_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign qstat.full  = (count_r == pcss_pkg::QCNT_W'(pcss_pkg::QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign head_cmd    = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + pcss_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - pcss_pkg::QCNT_W'(1);
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + pcss_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pcss_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // no overflow or underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!qstat.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue pop while empty");
`endif

endmodule

>>> sv/pcss_back.sv
module pcss_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcss_pkg::pcss_cmd_t    head_cmd,
  input  pcss_pkg::pcss_qstat_t  qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pcss_pkg::pcss_out_t    out_data
);

  logic half_r, half_nxt;
  logic wr_beat;
  logic fire;

  // write beat goes first, tail beat second
  assign wr_beat   = head_cmd.has_write && !half_r;
  assign out_valid = !qstat.empty;
  assign fire      = out_valid && out_ready;

  always_comb begin
    out_data = '0;
    if (wr_beat) begin
      out_data.kind        = pcss_pkg::KIND_WRITE;
      out_data.target      = head_cmd.target;
      out_data.reg_address = head_cmd.reg_address;
      out_data.reg_data    = head_cmd.reg_data;
      out_data.last        = !head_cmd.tail_valid;
    end else begin
      out_data.kind   = head_cmd.tail_kind;
      out_data.target = head_cmd.has_write ? pcss_pkg::TGT_PHY0 : head_cmd.target;
      out_data.bad_op = head_cmd.bad_op;
      out_data.last   = 1'b1;
    end
  end

  // Step through the beats of the head command
  always_comb begin
    half_nxt = half_r;
    pop      = 1'b0;
    if (fire) begin
      if (wr_beat && head_cmd.tail_valid) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else begin
      half_r <= half_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // the second beat only exists for commands carrying both a write and a tail
  a_half_shape: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (!qstat.empty && head_cmd.has_write && head_cmd.tail_valid))
    else $error("tail pending without a two-beat head command");
`endif

endmodule

>>> sv/phy_config_stream_sequencer.sv
// PHY configuration stream sequencer.
// Input channel (in_valid/in_ready/in_data): one beat is either a stream
// halfword (func 0) or a training message from a PHY (func 1).
// Output channel (out_valid/out_ready/out_data): register writes, wait
// notices, done, training error and unknown-op results; last marks the final
// result caused by one input beat.
// cfg_wr_en/cfg_wr_data load the 24-bit entry count; write it while idle.
// Each result is held in the command queue before it appears on the output.
// Throughput: one input beat per cycle while the queue has room, each
// decoded as it is taken; the back drives one result per cycle while
// out_ready is high, and a write that completes the run gives two results.
// A four-entry command queue sits between decode and output. When the
// receiver stalls, input beats keep being taken until the queue fills; then
// in_ready drops until a command has drained.
// Reset (rst_n low, synchronous) clears the entry count, the decode state and
// the queue; the block is ready in the first cycle after reset.
// After done, a training error or an unknown op, all input is discarded
// until the next reset.
module phy_config_stream_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pcss_pkg::pcss_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pcss_pkg::pcss_out_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [pcss_pkg::ADDR_W-1:0]  cfg_wr_data
);

  logic                   push;
  logic                   pop;
  pcss_pkg::pcss_cmd_t    push_cmd;
  pcss_pkg::pcss_cmd_t    head_cmd;
  pcss_pkg::pcss_qstat_t  qstat;

  // Decode
  pcss_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .qstat       (qstat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Command queue
  pcss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  // Result output
  pcss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
